@@ hw/rtl/sbas_pkg.sv @@
`default_nettype none

package sbas_pkg;

   localparam int MAX_DIGITS = 16;
   localparam int DIGIT_W    = 4;
   localparam int MAG_W      = MAX_DIGITS * DIGIT_W;
   localparam int COUNT_W    = 5;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_SHL = 2'd2,
      OP_SHR = 2'd3
   } op_type;

   // One item as it travels down the digit chain. r0 holds the sum or A minus B,
   // r1 holds B minus A; c0 and c1 are the carry or borrow into the next digit,
   // cnt0 and cnt1 the number of significant digits seen so far.
   typedef struct packed {
      logic [MAG_W-1:0]   a_dig;
      logic [MAG_W-1:0]   b_dig;
      logic [MAG_W-1:0]   r0;
      logic [MAG_W-1:0]   r1;
      logic               c0;
      logic               c1;
      logic [COUNT_W-1:0] cnt0;
      logic [COUNT_W-1:0] cnt1;
      logic               eff_sub;
      logic               neg0;
      logic               neg1;
      logic               ovf_pre;
   } stage_type;

   // A nibble above nine reads as nine.
   function automatic logic [DIGIT_W-1:0] clamp_digit(input logic [DIGIT_W-1:0] nib);
      logic [DIGIT_W-1:0] res;
      res = (nib > 4'd9) ? 4'd9 : nib;
      return res;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sbas_front.sv @@
`default_nettype none

module sbas_front
   import sbas_pkg::*;
#(
   parameter int DIGITS = MAX_DIGITS
) (
   input  wire logic [1:0]       operation,
   input  wire logic [MAG_W-1:0] a_magnitude,
   input  wire logic             a_negative,
   input  wire logic [MAG_W-1:0] b_magnitude,
   input  wire logic             b_negative,
   output stage_type             stage
);

   localparam logic [MAG_W-1:0] KEEP_MASK = {MAG_W{1'b1}} >> (DIGIT_W * (MAX_DIGITS - DIGITS));

   logic [MAG_W-1:0] a_clamp;
   logic [MAG_W-1:0] b_clamp;
   logic             b_neg_eff;

   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (i < DIGITS) begin
            a_clamp[i*DIGIT_W +: DIGIT_W] = clamp_digit(a_magnitude[i*DIGIT_W +: DIGIT_W]);
            b_clamp[i*DIGIT_W +: DIGIT_W] = clamp_digit(b_magnitude[i*DIGIT_W +: DIGIT_W]);
         end else begin
            a_clamp[i*DIGIT_W +: DIGIT_W] = '0;
            b_clamp[i*DIGIT_W +: DIGIT_W] = '0;
         end
      end
   end

   assign b_neg_eff = b_negative ^ (op_type'(operation) == OP_SUB);

   always_comb begin
      stage         = '0;
      stage.neg0    = a_negative;
      unique case (op_type'(operation)) inside
         OP_ADD, OP_SUB: begin
            stage.a_dig   = a_clamp;
            stage.b_dig   = b_clamp;
            stage.eff_sub = a_negative ^ b_neg_eff;
            stage.neg1    = b_neg_eff;
         end
         OP_SHL: begin
            // Shifted copies of A meet a zero B, so the chain only counts digits.
            stage.a_dig   = (a_clamp << DIGIT_W) & KEEP_MASK;
            stage.ovf_pre = (a_clamp[(DIGITS-1)*DIGIT_W +: DIGIT_W] != '0);
         end
         OP_SHR: begin
            stage.a_dig   = a_clamp >> DIGIT_W;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/sbas_cell.sv @@
`default_nettype none

module sbas_cell
   import sbas_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      in_valid,
   input  wire stage_type in_stage,
   output logic           out_valid,
   output stage_type      out_stage
);

   logic [DIGIT_W-1:0] ad;
   logic [DIGIT_W-1:0] bd;
   logic [4:0]         t0;
   logic [4:0]         t1;
   logic [DIGIT_W-1:0] d0;
   logic [DIGIT_W-1:0] d1;
   logic               k0;
   logic               k1;
   logic               valid_ff;
   stage_type          stage_ff;
   stage_type          stage_in;

   assign ad = in_stage.a_dig[INDEX*DIGIT_W +: DIGIT_W];
   assign bd = in_stage.b_dig[INDEX*DIGIT_W +: DIGIT_W];

   always_comb begin
      if (in_stage.eff_sub) begin
         // Digit of A minus B and of B minus A, each with its own borrow.
         t0 = 5'd10 + {1'b0, ad} - {1'b0, bd} - {4'b0, in_stage.c0};
         t1 = 5'd10 + {1'b0, bd} - {1'b0, ad} - {4'b0, in_stage.c1};
         k0 = (t0 < 5'd10);
         k1 = (t1 < 5'd10);
         d0 = k0 ? t0[DIGIT_W-1:0] : 4'(t0 - 5'd10);
         d1 = k1 ? t1[DIGIT_W-1:0] : 4'(t1 - 5'd10);
      end else begin
         t0 = {1'b0, ad} + {1'b0, bd} + {4'b0, in_stage.c0};
         t1 = '0;
         k0 = (t0 >= 5'd10);
         k1 = 1'b0;
         d0 = k0 ? 4'(t0 - 5'd10) : t0[DIGIT_W-1:0];
         d1 = '0;
      end

      stage_in    = in_stage;
      stage_in.r0[INDEX*DIGIT_W +: DIGIT_W] = d0;
      stage_in.r1[INDEX*DIGIT_W +: DIGIT_W] = d1;
      stage_in.c0 = k0;
      stage_in.c1 = k1;
      if (d0 != '0) begin
         stage_in.cnt0 = COUNT_W'(INDEX + 1);
      end
      if (d1 != '0) begin
         stage_in.cnt1 = COUNT_W'(INDEX + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

`default_nettype wire

@@ hw/rtl/sbas_back.sv @@
`default_nettype none

module sbas_back
   import sbas_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire stage_type     in_stage,
   output logic               strobe,
   output logic [MAG_W-1:0]   sum_magnitude,
   output logic               sum_negative,
   output logic [COUNT_W-1:0] digit_count,
   output logic               overflow
);

   logic               pick_ba;
   logic [MAG_W-1:0]   mag_sel;
   logic [COUNT_W-1:0] cnt_sel;
   logic               neg_sel;
   logic               ovf;
   logic               nonzero;

   logic               strobe_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic               neg_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               ovf_ff;

   always_comb begin
      // A final borrow out of A minus B means B was larger.
      pick_ba = in_stage.eff_sub & in_stage.c0;
      mag_sel = pick_ba ? in_stage.r1   : in_stage.r0;
      cnt_sel = pick_ba ? in_stage.cnt1 : in_stage.cnt0;
      neg_sel = pick_ba ? in_stage.neg1 : in_stage.neg0;
      ovf     = in_stage.ovf_pre | (~in_stage.eff_sub & in_stage.c0);
      nonzero = (cnt_sel != '0) | ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= in_valid;
      end
      mag_ff <= mag_sel;
      neg_ff <= neg_sel & nonzero;
      cnt_ff <= (cnt_sel == '0) ? COUNT_W'(1) : cnt_sel;
      ovf_ff <= ovf;
   end

   assign strobe        = strobe_ff;
   assign sum_magnitude = mag_ff;
   assign sum_negative  = neg_ff;
   assign digit_count   = cnt_ff;
   assign overflow      = ovf_ff;

endmodule

`default_nettype wire

@@ hw/rtl/signed_bcd_add_sub_shift.sv @@
`default_nettype none

// Signed packed-BCD add, subtract and decimal shift unit.
//
// A request beat is taken at a rising clock edge where start is high and busy
// is low. busy never rises: the unit takes a new beat in every cycle, since
// each beat flows down a chain of DIGITS digit cells, one cell per cycle, with
// the carry and borrow handed from cell to cell in the pipeline registers.
// The result beat appears on the rsp_ ports, marked by rsp_strobe, once it
// has passed the registers of the DIGITS digit cells and then the one output
// register of the back end.
// Throughput is one beat per cycle, and results leave in request order.
// Each result is shown for a single cycle; the receiver cannot stall the
// unit and must take every strobed beat.
// A synchronous reset drops every beat in flight and clears the strobe; the
// unit is ready for a request in the cycle after reset is released.
module signed_bcd_add_sub_shift
   import sbas_pkg::*;
#(
   parameter int DIGITS = MAX_DIGITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_operation,
   input  wire logic [MAG_W-1:0]   req_a_magnitude,
   input  wire logic               req_a_negative,
   input  wire logic [MAG_W-1:0]   req_b_magnitude,
   input  wire logic               req_b_negative,
   output logic                    rsp_strobe,
   output logic [MAG_W-1:0]        rsp_sum_magnitude,
   output logic                    rsp_sum_negative,
   output logic [COUNT_W-1:0]      rsp_digit_count,
   output logic                    rsp_overflow
);

   // The pipeline has no back pressure, so it is always ready.
   assign busy = 1'b0;

   stage_type chain_stage [0:DIGITS];
   logic      chain_valid [0:DIGITS];

   // The front end clamps nibbles, drops digits above DIGITS, folds the
   // operation into an effective add or subtract, and pre-aligns A for shifts.
   sbas_front #(
      .DIGITS(DIGITS)
   ) u_front (
      .operation  (req_operation),
      .a_magnitude(req_a_magnitude),
      .a_negative (req_a_negative),
      .b_magnitude(req_b_magnitude),
      .b_negative (req_b_negative),
      .stage      (chain_stage[0])
   );

   assign chain_valid[0] = start & ~busy;

   // Cell i resolves digit i of the sum and of both differences and passes
   // the carries and digit counts to cell i + 1.
   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      sbas_cell #(
         .INDEX(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (chain_valid[i]),
         .in_stage (chain_stage[i]),
         .out_valid(chain_valid[i+1]),
         .out_stage(chain_stage[i+1])
      );
   end

   // The back end picks the difference with the right sign, sets the sign of
   // a zero result without overflow to positive and registers the result beat.
   sbas_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[DIGITS]),
      .in_stage     (chain_stage[DIGITS]),
      .strobe       (rsp_strobe),
      .sum_magnitude(rsp_sum_magnitude),
      .sum_negative (rsp_sum_negative),
      .digit_count  (rsp_digit_count),
      .overflow     (rsp_overflow)
   );

   // Every request beat comes out after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(DIGITS + 1) rsp_strobe)
      else $error("result beat missing after fixed latency");

   // No result beat follows a reset cycle.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe after reset");

   // The digit count covers every nonzero digit and stays in range.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_count >= COUNT_W'(1)) &&
                     (rsp_digit_count <= COUNT_W'(DIGITS)) &&
                     ((rsp_sum_magnitude >> (DIGIT_W * rsp_digit_count)) == '0))
      else $error("digit count does not match magnitude");

   // A zero result without overflow is always positive.
   a_zero_positive: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_sum_magnitude == '0 && !rsp_overflow) |-> !rsp_sum_negative)
      else $error("negative zero result");

endmodule

`default_nettype wire

@@ tb/bcd_result_checker.sv @@
`default_nettype none

// Watches the request and result channels of the decimal unit. It predicts
// every accepted request beat, queues the prediction, and compares each
// strobed result beat with the oldest prediction, field by field.
module bcd_result_checker
   import sbas_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [1:0]         req_operation,
   input  wire logic [MAG_W-1:0]   req_a_magnitude,
   input  wire logic               req_a_negative,
   input  wire logic [MAG_W-1:0]   req_b_magnitude,
   input  wire logic               req_b_negative,
   input  wire logic               rsp_strobe,
   input  wire logic [MAG_W-1:0]   rsp_sum_magnitude,
   input  wire logic               rsp_sum_negative,
   input  wire logic [COUNT_W-1:0] rsp_digit_count,
   input  wire logic               rsp_overflow,
   output int                      mismatch_count,
   output int                      results_owed
);

   typedef struct {
      logic [MAG_W-1:0]   magnitude;
      logic               negative;
      logic [COUNT_W-1:0] digits;
      logic               overflow;
   } bcd_result_type;

   bcd_result_type expected_sums[$];
   int             errors = 0;
   int             owed   = 0;

   assign mismatch_count = errors;
   assign results_owed   = owed;

   // Packed BCD to binary; a nibble above nine reads as nine.
   function automatic longint unsigned bcd_to_binary(input logic [MAG_W-1:0] digits_in);
      longint unsigned value;
      logic [DIGIT_W-1:0] nib;
      value = 0;
      for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
         nib = digits_in[DIGIT_W*i +: DIGIT_W];
         if (nib > 4'd9) begin
            nib = 4'd9;
         end
         value = value * 10 + nib;
      end
      return value;
   endfunction

   function automatic logic [MAG_W-1:0] binary_to_bcd(input longint unsigned value);
      logic [MAG_W-1:0] digits_out;
      digits_out = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         digits_out[DIGIT_W*i +: DIGIT_W] = DIGIT_W'(value % 10);
         value = value / 10;
      end
      return digits_out;
   endfunction

   function automatic bcd_result_type predict_sum(input op_type op,
                                                  input logic [MAG_W-1:0] a_mag,
                                                  input logic a_neg,
                                                  input logic [MAG_W-1:0] b_mag,
                                                  input logic b_neg);
      bcd_result_type  res;
      longint unsigned a, b, mag, kept, span, rest;
      logic            an, bn, neg;
      int              count;
      span = 1;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         span = span * 10;
      end
      a  = bcd_to_binary(a_mag);
      an = a_neg && (a != 0);
      case (op) inside
         OP_ADD, OP_SUB: begin
            b  = bcd_to_binary(b_mag);
            bn = b_neg ^ (op == OP_SUB);
            if (b == 0) begin
               bn = 1'b0;
            end
            if (an == bn) begin
               mag = a + b;
               neg = an;
            end else if (a >= b) begin
               mag = a - b;
               neg = an;
            end else begin
               mag = b - a;
               neg = bn;
            end
         end
         OP_SHL: begin
            mag = a * 10;
            neg = an;
         end
         default: begin
            mag = a / 10;
            neg = an;
         end
      endcase
      if (mag == 0) begin
         neg = 1'b0;
      end
      kept  = mag % span;
      count = 0;
      rest  = kept;
      while (rest != 0) begin
         count++;
         rest = rest / 10;
      end
      if (count == 0) begin
         count = 1;
      end
      res.magnitude = binary_to_bcd(kept);
      res.negative  = neg;
      res.digits    = COUNT_W'(count);
      res.overflow  = (mag >= span);
      return res;
   endfunction

   task automatic check_field(input string field, input logic [MAG_W-1:0] want,
                              input logic [MAG_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      bcd_result_type want;
      if (!reset) begin
         if (start && !busy) begin
            expected_sums.push_back(predict_sum(op_type'(req_operation), req_a_magnitude,
                                                req_a_negative, req_b_magnitude,
                                                req_b_negative));
         end
         if (rsp_strobe) begin
            if (expected_sums.size() == 0) begin
               $display("%0t: result beat with none expected, expected nothing, actual %h",
                        $time, rsp_sum_magnitude);
               errors++;
            end else begin
               want = expected_sums.pop_front();
               check_field("sum_magnitude", want.magnitude, rsp_sum_magnitude);
               check_field("sum_negative", MAG_W'(want.negative), MAG_W'(rsp_sum_negative));
               check_field("digit_count", MAG_W'(want.digits), MAG_W'(rsp_digit_count));
               check_field("overflow", MAG_W'(want.overflow), MAG_W'(rsp_overflow));
            end
         end
      end
      owed <= expected_sums.size();
   end

endmodule

`default_nettype wire

@@ tb/tb_signed_bcd_add_sub_shift.sv @@
`default_nettype none

// Top of the testbench for the signed packed-BCD unit. This module only makes
// stimulus and gives the verdict; all prediction and comparison happen in the
// checker instantiated beside the block.
module tb_signed_bcd_add_sub_shift;
   import sbas_pkg::*;

   // After the last expected result, the tail keeps watching for stray result beats.
   localparam int DRAIN_CYCLES = 40;
   // Roughly 925 beats with their idle gaps plus the pauses; the limit leaves a
   // wide margin above that.
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BEATS = 900;
   localparam logic [MAG_W-1:0] ALL_NINES = 64'h9999_9999_9999_9999;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_operation   = OP_ADD;
   logic [MAG_W-1:0]   req_a_magnitude = '0;
   logic               req_a_negative  = 1'b0;
   logic [MAG_W-1:0]   req_b_magnitude = '0;
   logic               req_b_negative  = 1'b0;
   logic               rsp_strobe;
   logic [MAG_W-1:0]   rsp_sum_magnitude;
   logic               rsp_sum_negative;
   logic [COUNT_W-1:0] rsp_digit_count;
   logic               rsp_overflow;
   int                 mismatch_count;
   int                 results_owed;

   // Number of upcoming beats that are sent back to back with no gap.
   int                 burst_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   signed_bcd_add_sub_shift dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_a_magnitude   (req_a_magnitude),
      .req_a_negative    (req_a_negative),
      .req_b_magnitude   (req_b_magnitude),
      .req_b_negative    (req_b_negative),
      .rsp_strobe        (rsp_strobe),
      .rsp_sum_magnitude (rsp_sum_magnitude),
      .rsp_sum_negative  (rsp_sum_negative),
      .rsp_digit_count   (rsp_digit_count),
      .rsp_overflow      (rsp_overflow)
   );

   bcd_result_checker result_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_a_magnitude   (req_a_magnitude),
      .req_a_negative    (req_a_negative),
      .req_b_magnitude   (req_b_magnitude),
      .req_b_negative    (req_b_negative),
      .rsp_strobe        (rsp_strobe),
      .rsp_sum_magnitude (rsp_sum_magnitude),
      .rsp_sum_negative  (rsp_sum_negative),
      .rsp_digit_count   (rsp_digit_count),
      .rsp_overflow      (rsp_overflow),
      .mismatch_count    (mismatch_count),
      .results_owed      (results_owed)
   );

   // Draws one random operand. Most operands are well-formed BCD of a random
   // length, with a bias toward the full sixteen digits so that sums can run
   // past the top digit. A few are raw bit patterns, which exercise nibbles
   // above nine and make every bit of the port toggle, and a few have a run of
   // nines in the top digits, which sit right at the overflow boundary.
   function automatic logic [MAG_W-1:0] random_operand();
      logic [MAG_W-1:0] value;
      int               kind;
      int               len;
      value = '0;
      kind  = $urandom_range(0, 19);
      if (kind < 2) begin
         value = {$urandom, $urandom};
      end else if (kind < 4) begin
         len = $urandom_range(1, MAX_DIGITS);
         value = {$urandom, $urandom};
         for (int i = 0; i < MAX_DIGITS; i++) begin
            value[DIGIT_W*i +: DIGIT_W] = (i >= MAX_DIGITS - len) ? 4'd9 :
                                          DIGIT_W'($urandom_range(0, 9));
         end
      end else if (kind != 4) begin
         len = ($urandom_range(0, 3) == 0) ? MAX_DIGITS : $urandom_range(0, MAX_DIGITS);
         for (int i = 0; i < len; i++) begin
            value[DIGIT_W*i +: DIGIT_W] = DIGIT_W'($urandom_range(0, 9));
         end
      end
      return value;
   endfunction

   // Sends one request beat. Outside a burst the sender may idle before the
   // beat; inside a burst, beats follow each other with no gap.
   // While idle, start is low and the payload ports carry noise. The beat is
   // held until an edge finds busy low; busy is sampled right after the edge,
   // so it is the value that decided acceptance.
   task automatic send_beat(input op_type op, input logic [MAG_W-1:0] a_mag,
                            input logic a_neg, input logic [MAG_W-1:0] b_mag,
                            input logic b_neg);
      int gap;
      if (burst_left > 0) begin
         gap = 0;
         burst_left--;
      end else begin
         gap = $urandom_range(0, 6);
         if ($urandom_range(0, 39) == 0) begin
            burst_left = $urandom_range(10, 40);
         end
      end
      if (gap > 0) begin
         start <= 1'b0;
      end
      repeat (gap) begin
         req_operation   <= 2'($urandom_range(0, 3));
         req_a_magnitude <= {$urandom, $urandom};
         req_a_negative  <= 1'($urandom_range(0, 1));
         req_b_magnitude <= {$urandom, $urandom};
         req_b_negative  <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_a_magnitude <= a_mag;
      req_a_negative  <= a_neg;
      req_b_magnitude <= b_mag;
      req_b_negative  <= b_neg;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   // Drops start and waits until the checker owes no result. The first edge
   // lets the owed count take in a beat accepted at the current edge.
   task automatic wait_for_results();
      start <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: zero, the largest values, every operation, and the
      // corner cases of sign, overflow and out-of-range nibbles.
      send_beat(OP_ADD, '0, 1'b0, '0, 1'b0);
      send_beat(OP_ADD, ALL_NINES, 1'b0, ALL_NINES, 1'b0);
      // Overflow where every kept digit is zero still reports a negative sign.
      send_beat(OP_ADD, ALL_NINES, 1'b1, 64'h1, 1'b1);
      send_beat(OP_SUB, ALL_NINES, 1'b1, 64'h1, 1'b0);
      // A minus itself gives zero, which must come back positive.
      send_beat(OP_SUB, 64'h1234_5678_9012_3456, 1'b1, 64'h1234_5678_9012_3456, 1'b1);
      // Negative zero operands count as positive.
      send_beat(OP_ADD, '0, 1'b1, 64'h5, 1'b0);
      send_beat(OP_SUB, 64'h5, 1'b0, '0, 1'b1);
      send_beat(OP_ADD, '0, 1'b1, '0, 1'b1);
      // Mixed signs where B outweighs A, so the sign follows B; then a borrow chain.
      send_beat(OP_ADD, 64'h17, 1'b0, 64'h4321, 1'b1);
      send_beat(OP_SUB, 64'h17, 1'b1, 64'h4321, 1'b1);
      send_beat(OP_SUB, 64'h1000_0000_0000_0000, 1'b0, 64'h1, 1'b0);
      // Nibbles above nine read as nine.
      send_beat(OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, 1'b0);
      send_beat(OP_SUB, 64'hABCD_EFAB_CDEF_ABCD, 1'b1, 64'hFEDC_BAFE_DCBA_FEDC, 1'b1);
      // Shift left, with and without a nonzero top digit; B is ignored.
      send_beat(OP_SHL, 64'h0123_4567_8901_2345, 1'b1, ALL_NINES, 1'b1);
      send_beat(OP_SHL, 64'h9000_0000_0000_0000, 1'b0, '0, 1'b0);
      send_beat(OP_SHL, ALL_NINES, 1'b1, '0, 1'b0);
      send_beat(OP_SHL, '0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_beat(OP_SHL, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, 1'b0);
      // Shift right, including a single digit that truncates to positive zero.
      send_beat(OP_SHR, 64'h5, 1'b1, '0, 1'b0);
      send_beat(OP_SHR, ALL_NINES, 1'b1, ALL_NINES, 1'b0);
      send_beat(OP_SHR, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, 1'b1);
      send_beat(OP_SHR, 64'h10, 1'b0, '0, 1'b0);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // Twice during the run the sender stops until the pipeline is empty,
         // so that new beats also enter an idle unit.
         if (n == RANDOM_BEATS / 3 || n == 2 * RANDOM_BEATS / 3) begin
            wait_for_results();
         end
         send_beat(op_type'($urandom_range(0, 3)), random_operand(),
                   1'($urandom_range(0, 1)), random_operand(), 1'($urandom_range(0, 1)));
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("tb_signed_bcd_add_sub_shift OK");
      end else begin
         $display("tb_signed_bcd_add_sub_shift NOT OK");
      end
      $finish;
   end

   // Watchdog: a run that has not finished within the limit is a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_signed_bcd_add_sub_shift NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/sbas_pkg.sv
hw/rtl/sbas_front.sv
hw/rtl/sbas_cell.sv
hw/rtl/sbas_back.sv
hw/rtl/signed_bcd_add_sub_shift.sv
tb/bcd_result_checker.sv
tb/tb_signed_bcd_add_sub_shift.sv
